>>> design/hdlf_pkg.sv
// hdlf_pkg: shared types, defaults and character helpers for the hex dump line formatter
// used by hdlf_ctrl, hdlf_dp and hex_dump_line_formatter_top; no dependencies
package hdlf_pkg;

	localparam int BYTES_PER_LINE_DEF = 16;
	localparam int HEX_COLUMN_DEF     = 10;
	localparam int TEXT_COLUMN_DEF    = 60;
	localparam int NEWLINE_COLUMN_DEF = 76;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DOT   = 8'h2e;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] PRINT_LOW  = 8'd32;
	localparam logic [7:0] PRINT_HIGH = 8'd126;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LINE,
		S_END
	} state_t;

	typedef struct packed {
		logic store;
		logic emit_chunk;
		logic emit_end;
	} cmd_t;

	typedef struct packed {
		logic fill_last;
		logic fill_nz;
		logic out_room;
		logic last_chunk;
	} status_t;

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] w;
		w = {4'h0, v};
		return (v < 4'd10) ? (8'h30 + w) : (8'h57 + w);
	endfunction

	function automatic logic [7:0] text_char(input logic [7:0] b);
		return (b < PRINT_LOW || b > PRINT_HIGH) ? CHAR_DOT : b;
	endfunction

endpackage

>>> design/hdlf_ctrl.sv
// hdlf_ctrl: sequencing state machine of the hex dump line formatter
// depends on hdlf_pkg; drives hdlf_dp through cmd_t and reads its status_t
module hdlf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              s_tuser,
	input  logic              s_tlast,
	input  hdlf_pkg::status_t status,
	output hdlf_pkg::cmd_t    cmd
);

	hdlf_pkg::state_t state_q, state_d;
	logic end_pend_q, end_pend_d;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= hdlf_pkg::S_IDLE;
			end_pend_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			end_pend_q <= end_pend_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		end_pend_d = end_pend_q;
		cmd        = '0;
		s_tready   = 1'b0;
		accept     = 1'b0;
		case (state_q)
			hdlf_pkg::S_IDLE: begin
				s_tready  = 1'b1;
				accept    = s_tvalid;
				cmd.store = accept && s_tuser;
				if (accept) begin
					if (s_tuser && status.fill_last) begin
						state_d    = hdlf_pkg::S_LINE;
						end_pend_d = s_tlast;
					end else if (s_tlast) begin
						end_pend_d = 1'b1;
						if (s_tuser || status.fill_nz) begin
							state_d = hdlf_pkg::S_LINE;
						end else begin
							state_d = hdlf_pkg::S_END;
						end
					end
				end
			end
			hdlf_pkg::S_LINE: begin
				if (status.out_room) begin
					cmd.emit_chunk = 1'b1;
					if (status.last_chunk) begin
						state_d = end_pend_q ? hdlf_pkg::S_END : hdlf_pkg::S_IDLE;
					end
				end
			end
			hdlf_pkg::S_END: begin
				if (status.out_room) begin
					cmd.emit_end = 1'b1;
					end_pend_d   = 1'b0;
					state_d      = hdlf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = hdlf_pkg::S_IDLE;
			end
		endcase
	end

	// end beat only goes out once the line buffer is drained
	a_end_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_end |-> !status.fill_nz)
		else $error("end beat with bytes still buffered");

	// a full line always ends with its last chunk before new input
	a_line_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hdlf_pkg::S_LINE) && !cmd.emit_chunk |=> state_q == hdlf_pkg::S_LINE)
		else $error("line emission left without sending a chunk");

endmodule

>>> design/hdlf_dp.sv
// hdlf_dp: line row register, fill and offset counters, chunk output register
// depends on hdlf_pkg; commanded by hdlf_ctrl
module hdlf_dp #(
	parameter int BYTES_PER_LINE = hdlf_pkg::BYTES_PER_LINE_DEF,
	parameter int HEX_COLUMN     = hdlf_pkg::HEX_COLUMN_DEF,
	parameter int TEXT_COLUMN    = hdlf_pkg::TEXT_COLUMN_DEF,
	parameter int NEWLINE_COLUMN = hdlf_pkg::NEWLINE_COLUMN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        data_byte,
	input  hdlf_pkg::cmd_t    cmd,
	output hdlf_pkg::status_t status,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [71:0]       m_tdata,
	output logic              m_tlast
);

	localparam int LINE_LEN  = NEWLINE_COLUMN + 1;
	localparam int NCH       = (LINE_LEN + 7) / 8;
	localparam int ROW_CHARS = NCH * 8;
	localparam int LAST_N    = LINE_LEN - 8 * (NCH - 1);
	localparam int FILL_W    = $clog2(BYTES_PER_LINE + 1);
	localparam int CH_W      = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int NL_CHUNK  = NEWLINE_COLUMN / 8;
	localparam int NL_LANE   = NEWLINE_COLUMN % 8;

	logic [7:0]           row_q [ROW_CHARS];
	logic [ROW_CHARS-1:0] lock_q;
	logic [FILL_W-1:0]    fill_q;
	logic [31:0]          offset_q;
	logic [CH_W-1:0]      chunk_q;
	logic                 out_valid_q;
	logic [71:0]          out_data_q;
	logic                 out_last_q;

	logic [7:0]  hex_hi, hex_lo, txt;
	logic [63:0] chunk_text;
	logic [3:0]  chunk_cnt;
	logic        last_chunk;

	assign hex_hi     = hdlf_pkg::hex_char(data_byte[7:4]);
	assign hex_lo     = hdlf_pkg::hex_char(data_byte[3:0]);
	assign txt        = hdlf_pkg::text_char(data_byte);
	assign last_chunk = (chunk_q == CH_W'(NCH - 1));

	for (genvar p = 0; p < ROW_CHARS; p++) begin : g_pos
		localparam int HOFF   = p - HEX_COLUMN;
		localparam int TOFF   = p - TEXT_COLUMN;
		localparam bit IS_HI  = (HOFF >= 0) && (HOFF % 3 == 0) && (HOFF / 3 < BYTES_PER_LINE);
		localparam bit IS_LO  = (HOFF >= 1) && (HOFF % 3 == 1) && (HOFF / 3 < BYTES_PER_LINE);
		localparam bit IS_TXT = (TOFF >= 0) && (TOFF < BYTES_PER_LINE);
		localparam int HI_IDX = IS_HI ? HOFF / 3 : 0;
		localparam int LO_IDX = IS_LO ? HOFF / 3 : 0;
		localparam int TX_IDX = IS_TXT ? TOFF : 0;

		logic hit_hi, hit_lo, hit_txt;
		logic [7:0] shift_in;
		logic       lock_in;

		assign hit_hi  = IS_HI && (fill_q == FILL_W'(HI_IDX));
		assign hit_lo  = IS_LO && (fill_q == FILL_W'(LO_IDX));
		assign hit_txt = IS_TXT && (fill_q == FILL_W'(TX_IDX));

		if (p + 8 < ROW_CHARS) begin : g_shift
			assign shift_in = row_q[p + 8];
			assign lock_in  = lock_q[p + 8];
		end else begin : g_fill
			assign shift_in = hdlf_pkg::CHAR_SPACE;
			assign lock_in  = 1'b0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				row_q[p]  <= hdlf_pkg::CHAR_SPACE;
				lock_q[p] <= 1'b0;
			end else if (cmd.emit_chunk) begin
				row_q[p]  <= shift_in;
				lock_q[p] <= lock_in;
			end else if (cmd.store) begin
				if (hit_txt) begin
					row_q[p]  <= txt;
					lock_q[p] <= 1'b1;
				end else if (hit_hi && !lock_q[p]) begin
					row_q[p] <= hex_hi;
				end else if (hit_lo && !lock_q[p]) begin
					row_q[p] <= hex_lo;
				end
			end
		end
	end

	always_comb begin
		logic [7:0] ch;
		chunk_text = '0;
		for (int l = 0; l < 8; l++) begin
			ch = row_q[l];
			if (chunk_q == '0) begin
				ch = hdlf_pkg::hex_char(offset_q[31 - 4 * l -: 4]);
			end
			if (chunk_q == CH_W'(NL_CHUNK) && l == NL_LANE) begin
				ch = hdlf_pkg::CHAR_LF;
			end
			if (last_chunk && l >= LAST_N) begin
				ch = 8'h00;
			end
			chunk_text[8 * l +: 8] = ch;
		end
		chunk_cnt = last_chunk ? 4'(LAST_N) : 4'd8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			offset_q    <= '0;
			chunk_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit_chunk) begin
				if (last_chunk) begin
					chunk_q  <= '0;
					fill_q   <= '0;
					offset_q <= offset_q + 32'(fill_q);
				end else begin
					chunk_q <= chunk_q + 1'b1;
				end
			end else if (cmd.store) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.emit_chunk || cmd.emit_end) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_chunk) begin
			out_data_q <= {4'h0, chunk_cnt, chunk_text};
			out_last_q <= last_chunk;
		end else if (cmd.emit_end) begin
			out_data_q <= '0;
			out_last_q <= 1'b1;
		end
	end

	assign status.fill_last  = (fill_q == FILL_W'(BYTES_PER_LINE - 1));
	assign status.fill_nz    = (fill_q != '0);
	assign status.out_room   = !out_valid_q || m_tready;
	assign status.last_chunk = last_chunk;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// a finished line leaves the buffer empty
	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_chunk && last_chunk |=> fill_q == '0)
		else $error("fill count not cleared after line");

	// bytes are never stored into a full buffer
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> fill_q < FILL_W'(BYTES_PER_LINE))
		else $error("store into full line buffer");

	// a zero-count beat carries no text
	a_end_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[67:64] == 4'd0 |-> m_tlast && m_tdata[63:0] == 64'd0)
		else $error("malformed end beat");

endmodule

>>> design/hex_dump_line_formatter_top.sv
// hex_dump_line_formatter_top: hex dump line formatter, stream in, text chunks out
// depends on hdlf_pkg, hdlf_ctrl and hdlf_dp
//
// Input beats carry one byte each (s_tdata), s_tuser flags that the byte is
// present and s_tlast marks end of data after that beat's byte. Bytes are
// written straight into a text row register, so bytes that do not
// complete a line are accepted back to back.
// When a line is full, or at end of data with bytes buffered, the row is sent
// as ceil((NEWLINE_COLUMN+1)/8) chunks (10 at the defaults), one per cycle
// while the receiver takes them; the accepting edge moves the state to
// S_LINE, which loads the first chunk into the output register once it has
// room. s_tready stays low while a line or the end beat is being sent. End
// of data adds one end beat (count 0, tlast high). The single output
// register sets the rate: a stall on m_tready holds the current beat and
// freezes line emission; input is taken again once the last chunk is
// loaded. Reset clears the row to spaces, the fill count and the running
// offset; no clearing pass is needed.
module hex_dump_line_formatter_top #(
	parameter int BYTES_PER_LINE = hdlf_pkg::BYTES_PER_LINE_DEF,
	parameter int HEX_COLUMN     = hdlf_pkg::HEX_COLUMN_DEF,
	parameter int TEXT_COLUMN    = hdlf_pkg::TEXT_COLUMN_DEF,
	parameter int NEWLINE_COLUMN = hdlf_pkg::NEWLINE_COLUMN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // has_byte
	input  logic        s_tlast,   // end_of_data
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // text_chunk[63:0], char_count[67:64], zero pad
	output logic        m_tlast    // end_of_line
);

	hdlf_pkg::cmd_t    cmd;
	hdlf_pkg::status_t status;

	hdlf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.status   (status),
		.cmd      (cmd)
	);

	hdlf_dp #(
		.BYTES_PER_LINE (BYTES_PER_LINE),
		.HEX_COLUMN     (HEX_COLUMN),
		.TEXT_COLUMN    (TEXT_COLUMN),
		.NEWLINE_COLUMN (NEWLINE_COLUMN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
